@@ rtl/core/fbpa_pkg.sv @@
// Shared constants, codes and interface structs of the fixed block pool allocator.
package fbpa_pkg;

  // Depth of the free-offset stack.
  localparam int unsigned MAX_BLOCKS = 256;
  localparam int unsigned PTR_W      = $clog2(MAX_BLOCKS);
  localparam int unsigned CNT_W      = $clog2(MAX_BLOCKS + 1);

  localparam int unsigned ADDR_W     = 32;
  localparam int unsigned SIZE_W     = 16;
  localparam int unsigned NBLK_W     = 9;
  localparam int unsigned OFF_W      = 24;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned STATUS_W   = 3;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_TOO_LARGE  = 3'd1,
    ST_BAD_ALIGN  = 3'd2,
    ST_EMPTY      = 3'd3,
    ST_MISALIGNED = 3'd4,
    ST_IGNORED    = 3'd5,
    ST_FULL       = 3'd6
  } status_t;

  typedef enum logic {
    OP_ALLOC   = 1'b0,
    OP_RELEASE = 1'b1
  } op_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POOL_BASE  = 2'd0,
    CFG_BLOCK_SIZE = 2'd1,
    CFG_NUM_BLOCKS = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [ADDR_W-1:0] pool_base;
    logic [SIZE_W-1:0] blk_bytes;
    logic [CNT_W-1:0]  eff_blocks;
    logic [ADDR_W:0]   pool_limit;
    logic              rebuild;
  } cfg_view_t;

  typedef struct packed {
    logic [OFF_W-1:0] top;
    logic [CNT_W-1:0] count;
  } stack_view_t;

  typedef struct packed {
    logic             pop;
    logic             push;
    logic [OFF_W-1:0] push_off;
  } stack_cmd_t;

  typedef struct packed {
    op_t               op;
    logic [SIZE_W-1:0] size;
    logic [SIZE_W-1:0] align;
    logic [ADDR_W-1:0] addr;
  } item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    status_t           status;
  } result_t;

endpackage

@@ rtl/core/fbpa_cfg.sv @@
// Configuration registers, pool bounds and the rebuild cycle of the allocator.
module fbpa_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0]     cfg_wr_data,
  output fbpa_pkg::cfg_view_t                 cfg
);

  logic [fbpa_pkg::ADDR_W-1:0]           pool_base_r;
  logic [fbpa_pkg::SIZE_W-1:0]           blk_bytes_r;
  logic [fbpa_pkg::NBLK_W-1:0]           num_blocks_r;
  logic                                  rebuild_r;
  logic [fbpa_pkg::ADDR_W:0]             pool_limit_r;
  logic [fbpa_pkg::ADDR_W:0]             pool_limit_nxt;
  logic [fbpa_pkg::CNT_W-1:0]            eff_blocks;
  logic [fbpa_pkg::CNT_W+fbpa_pkg::SIZE_W-1:0] span;
  logic                                  known_idx;

  // Pool sizes above the stack depth are clamped to it.
  assign eff_blocks = (32'(num_blocks_r) > fbpa_pkg::MAX_BLOCKS) ?
                      fbpa_pkg::CNT_W'(fbpa_pkg::MAX_BLOCKS) :
                      fbpa_pkg::CNT_W'(num_blocks_r);

  assign span           = eff_blocks * blk_bytes_r;
  assign pool_limit_nxt = {1'b0, pool_base_r} + (fbpa_pkg::ADDR_W + 1)'(span);

  assign known_idx = (cfg_index == fbpa_pkg::CFG_POOL_BASE) ||
                     (cfg_index == fbpa_pkg::CFG_BLOCK_SIZE) ||
                     (cfg_index == fbpa_pkg::CFG_NUM_BLOCKS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r  <= '0;
      blk_bytes_r  <= fbpa_pkg::SIZE_W'(64);
      num_blocks_r <= fbpa_pkg::NBLK_W'(256);
      rebuild_r    <= 1'b1;
    end else begin
      rebuild_r <= cfg_wr_en && known_idx;
      if (cfg_wr_en) begin
        case (cfg_index)
          fbpa_pkg::CFG_POOL_BASE:  pool_base_r  <= cfg_wr_data[fbpa_pkg::ADDR_W-1:0];
          fbpa_pkg::CFG_BLOCK_SIZE: blk_bytes_r  <= cfg_wr_data[fbpa_pkg::SIZE_W-1:0];
          fbpa_pkg::CFG_NUM_BLOCKS: num_blocks_r <= cfg_wr_data[fbpa_pkg::NBLK_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // The end bound is only refreshed in the rebuild cycle, with settled registers.
  always_ff @(posedge clk) begin
    if (rebuild_r) begin
      pool_limit_r <= pool_limit_nxt;
    end
  end

  assign cfg.pool_base  = pool_base_r;
  assign cfg.blk_bytes  = blk_bytes_r;
  assign cfg.eff_blocks = eff_blocks;
  assign cfg.pool_limit = pool_limit_r;
  assign cfg.rebuild    = rebuild_r;

endmodule

@@ rtl/core/fbpa_stack.sv @@
// Free-offset stack: memory, cached top entry and prefetched entry below it.
module fbpa_stack (
  input  logic                     clk,
  input  logic                     rst_n,
  input  fbpa_pkg::cfg_view_t      cfg,
  input  fbpa_pkg::stack_cmd_t     cmd,
  output fbpa_pkg::stack_view_t    view
);

  logic [fbpa_pkg::OFF_W-1:0]      mem [fbpa_pkg::MAX_BLOCKS];
  logic [fbpa_pkg::MAX_BLOCKS-1:0] vld_r;
  logic [fbpa_pkg::CNT_W-1:0]      count_r;
  logic [fbpa_pkg::CNT_W-1:0]      count_nxt;
  logic [fbpa_pkg::OFF_W-1:0]      top_r;
  logic [fbpa_pkg::OFF_W-1:0]      top_nxt;
  logic [fbpa_pkg::OFF_W-1:0]      k_r;
  logic [fbpa_pkg::OFF_W-1:0]      k_nxt;
  logic [fbpa_pkg::OFF_W-1:0]      rd_data_r;
  logic                            rd_vld_r;
  logic [fbpa_pkg::OFF_W-1:0]      below;
  logic [fbpa_pkg::OFF_W-1:0]      bs_ext;
  logic [fbpa_pkg::CNT_W-1:0]      rd_idx;
  logic [fbpa_pkg::PTR_W-1:0]      rd_addr;
  logic [fbpa_pkg::PTR_W-1:0]      wr_addr;
  logic [fbpa_pkg::OFF_W+fbpa_pkg::CNT_W-1:0] top_prod;
  logic [fbpa_pkg::OFF_W+fbpa_pkg::CNT_W-1:0] k_prod;

  // k_r tracks (count - 2) times the block size, the reset value of the entry under the top.
  assign bs_ext   = fbpa_pkg::OFF_W'(cfg.blk_bytes);
  assign top_prod = (cfg.eff_blocks - fbpa_pkg::CNT_W'(1)) * cfg.blk_bytes;
  assign k_prod   = (cfg.eff_blocks - fbpa_pkg::CNT_W'(2)) * cfg.blk_bytes;

  // An entry never written since the last rebuild reads as its reset value.
  assign below = rd_vld_r ? rd_data_r : k_r;

  always_comb begin
    count_nxt = count_r;
    top_nxt   = top_r;
    k_nxt     = k_r;
    if (cfg.rebuild) begin
      count_nxt = cfg.eff_blocks;
      top_nxt   = top_prod[fbpa_pkg::OFF_W-1:0];
      k_nxt     = k_prod[fbpa_pkg::OFF_W-1:0];
    end else if (cmd.pop) begin
      count_nxt = count_r - fbpa_pkg::CNT_W'(1);
      top_nxt   = below;
      k_nxt     = k_r - bs_ext;
    end else if (cmd.push) begin
      count_nxt = count_r + fbpa_pkg::CNT_W'(1);
      top_nxt   = cmd.push_off;
      k_nxt     = k_r + bs_ext;
    end
  end

  assign rd_idx  = count_nxt - fbpa_pkg::CNT_W'(2);
  assign rd_addr = rd_idx[fbpa_pkg::PTR_W-1:0];
  assign wr_addr = count_r[fbpa_pkg::PTR_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      mem[wr_addr] <= cmd.push_off;
    end
    rd_data_r <= mem[rd_addr];
    top_r     <= top_nxt;
    k_r       <= k_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (cfg.rebuild) begin
        vld_r    <= '0;
        rd_vld_r <= 1'b0;
      end else begin
        if (cmd.push) begin
          vld_r[wr_addr] <= 1'b1;
        end
        rd_vld_r <= vld_r[rd_addr];
      end
    end
  end

  assign view.top   = top_r;
  assign view.count = count_r;

  a_pop_push_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.pop && cmd.push))
    else $error("stack pop and push in the same cycle");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop |-> (count_r != '0))
    else $error("pop from an empty stack");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> (32'(count_r) < fbpa_pkg::MAX_BLOCKS))
    else $error("push onto a full stack");

  a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.pop && !cfg.rebuild) |=> (count_r == $past(count_r) - fbpa_pkg::CNT_W'(1)))
    else $error("pop did not decrement the fill count");

endmodule

@@ rtl/core/fbpa_exec.sv @@
// Allocate and release decision for one item against the current stack top.
module fbpa_exec (
  input  logic                   go,
  input  fbpa_pkg::item_t        item,
  input  fbpa_pkg::cfg_view_t    cfg,
  input  fbpa_pkg::stack_view_t  stk,
  output fbpa_pkg::stack_cmd_t   cmd,
  output fbpa_pkg::result_t      res
);

  logic [fbpa_pkg::SIZE_W-1:0] align_m1;
  logic                        align_ok;
  logic [fbpa_pkg::ADDR_W-1:0] cand_addr;
  logic                        misaligned;
  logic                        in_pool;
  logic                        full;
  logic [fbpa_pkg::ADDR_W-1:0] rel_off;

  assign align_m1   = item.align - fbpa_pkg::SIZE_W'(1);
  assign align_ok   = (item.align != '0) && ((item.align & align_m1) == '0);
  assign cand_addr  = cfg.pool_base + fbpa_pkg::ADDR_W'(stk.top);
  assign misaligned = (cand_addr[fbpa_pkg::SIZE_W-1:0] & align_m1) != '0;
  assign in_pool    = (item.addr != '0) && (item.addr >= cfg.pool_base) &&
                      ({1'b0, item.addr} < cfg.pool_limit);
  assign full       = 32'(stk.count) >= fbpa_pkg::MAX_BLOCKS;
  assign rel_off    = item.addr - cfg.pool_base;

  always_comb begin
    cmd.pop      = 1'b0;
    cmd.push     = 1'b0;
    cmd.push_off = rel_off[fbpa_pkg::OFF_W-1:0];
    res.addr     = '0;
    res.status   = fbpa_pkg::ST_OK;
    case (item.op)
      fbpa_pkg::OP_ALLOC: begin
        if (item.size > cfg.blk_bytes) begin
          res.status = fbpa_pkg::ST_TOO_LARGE;
        end else if (!align_ok) begin
          res.status = fbpa_pkg::ST_BAD_ALIGN;
        end else if (stk.count == '0) begin
          res.status = fbpa_pkg::ST_EMPTY;
        end else if (misaligned) begin
          res.status = fbpa_pkg::ST_MISALIGNED;
        end else begin
          cmd.pop  = go;
          res.addr = cand_addr;
        end
      end
      fbpa_pkg::OP_RELEASE: begin
        if (!in_pool) begin
          res.status = fbpa_pkg::ST_IGNORED;
        end else if (full) begin
          res.status = fbpa_pkg::ST_FULL;
        end else begin
          cmd.push = go;
        end
      end
      default: ;
    endcase
  end

endmodule

@@ rtl/core/fixed_block_pool_allocator_core.sv @@
// Top level of the fixed-size block pool allocator with its input and result registers.
//
// The allocator hands out fixed-size blocks from a pool at pool_base from a LIFO stack of
// free block offsets, and takes them back on release. It takes one item per clock cycle while
// the result side does not stall and no rebuild is under way. Each item is evaluated in the
// input register, which updates the stack and loads the result register, from which the
// result leaves. The stack top is
// kept in a register and the entry under it is read ahead from the stack memory every cycle,
// so back-to-back pops and pushes never wait on the memory port. After reset and after every
// configuration write to a known register the stack is rebuilt while in_ready is held low;
// entries that were never pushed since then read as their index times the block size,
// tracked by one valid bit per entry, so no clearing pass is needed. Configuration writes
// must only be issued while no transfer is in flight.
module fixed_block_pool_allocator_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_operation,
  input  logic [fbpa_pkg::SIZE_W-1:0]      in_request_size,
  input  logic [fbpa_pkg::SIZE_W-1:0]      in_alignment,
  input  logic [fbpa_pkg::ADDR_W-1:0]      in_release_address,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [fbpa_pkg::ADDR_W-1:0]      out_block_address,
  output logic [fbpa_pkg::STATUS_W-1:0]    out_status,
  input  logic                             cfg_wr_en,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [fbpa_pkg::CFG_DATA_W-1:0]  cfg_wr_data
);

  fbpa_pkg::cfg_view_t   cfg;
  fbpa_pkg::stack_view_t stk;
  fbpa_pkg::stack_cmd_t  cmd;
  fbpa_pkg::result_t     res;
  fbpa_pkg::item_t       s1_item_r;
  logic                  s1_valid_r;
  logic                  out_valid_r;
  fbpa_pkg::result_t     out_res_r;
  logic                  in_fire;
  logic                  out_load;

  // The result register takes a new result when it is empty or its content leaves this cycle.
  assign out_load = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !cfg.rebuild && (!s1_valid_r || out_load);
  assign in_fire  = in_valid && in_ready;

  fbpa_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .cfg         (cfg)
  );

  fbpa_stack u_stack (
    .clk   (clk),
    .rst_n (rst_n),
    .cfg   (cfg),
    .cmd   (cmd),
    .view  (stk)
  );

  // The stack only moves when the evaluated item actually lands in the result register.
  fbpa_exec u_exec (
    .go   (out_load),
    .item (s1_item_r),
    .cfg  (cfg),
    .stk  (stk),
    .cmd  (cmd),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_r <= 1'b1;
      end else if (out_load) begin
        s1_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_item_r.op    <= fbpa_pkg::op_t'(in_operation);
      s1_item_r.size  <= in_request_size;
      s1_item_r.align <= in_alignment;
      s1_item_r.addr  <= in_release_address;
    end
    if (out_load) begin
      out_res_r <= res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_block_address = out_res_r.addr;
  assign out_status        = out_res_r.status;

  a_no_accept_in_rebuild: assert property (@(posedge clk) disable iff (!rst_n)
    cfg.rebuild |-> !in_ready)
    else $error("item accepted while the stack is being rebuilt");

  a_load_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r)
    else $error("evaluated item did not reach the result register");

  a_stack_moves_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.pop || cmd.push) |-> out_load)
    else $error("stack changed without a result being loaded");

endmodule

@@ bench/fbpa_alloc_checker.sv @@
// Checker for the block pool allocator: predicts every result and compares it on transfer.
module fbpa_alloc_checker
  import fbpa_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  in_operation,
  input  logic [SIZE_W-1:0]     in_request_size,
  input  logic [SIZE_W-1:0]     in_alignment,
  input  logic [ADDR_W-1:0]     in_release_address,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [ADDR_W-1:0]     out_block_address,
  input  logic [STATUS_W-1:0]   out_status,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data,
  output int                    fail_count,
  output int                    outstanding
);

  localparam logic [SIZE_W-1:0] RESET_BLOCK_SIZE = 16'd64;
  localparam logic [NBLK_W-1:0] RESET_NUM_BLOCKS = 9'd256;

  logic [ADDR_W-1:0] base_cfg;
  logic [SIZE_W-1:0] bsize_cfg;
  logic [NBLK_W-1:0] nblk_cfg;

  logic [OFF_W-1:0]  free_offsets [MAX_BLOCKS];
  logic [CNT_W-1:0]  free_depth;

  result_t           pending_results [$];

  function automatic int unsigned usable_blocks();
    return (nblk_cfg > MAX_BLOCKS) ? MAX_BLOCKS : int'(nblk_cfg);
  endfunction

  // Entry i holds i block sizes, with the highest entry on top.
  task automatic rebuild_free_list();
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      free_offsets[i] = OFF_W'(i * bsize_cfg);
    end
    free_depth = CNT_W'(usable_blocks());
  endtask

  task automatic predict_alloc_result(input item_t req, output result_t res);
    logic [ADDR_W-1:0] cand;
    logic [ADDR_W:0]   pool_lim;
    res.addr   = '0;
    res.status = ST_OK;
    if (req.op == OP_ALLOC) begin
      if (req.size > bsize_cfg) begin
        res.status = ST_TOO_LARGE;
      end else if (req.align == '0 || (req.align & (req.align - SIZE_W'(1))) != '0) begin
        res.status = ST_BAD_ALIGN;
      end else if (free_depth == '0) begin
        res.status = ST_EMPTY;
      end else begin
        cand = base_cfg + ADDR_W'(free_offsets[PTR_W'(free_depth - 1'b1)]);
        // A misaligned top block is left where it is.
        if ((cand[SIZE_W-1:0] & (req.align - SIZE_W'(1))) != '0) begin
          res.status = ST_MISALIGNED;
        end else begin
          free_depth = free_depth - 1'b1;
          res.addr   = cand;
        end
      end
    end else begin
      pool_lim = {1'b0, base_cfg} + (ADDR_W + 1)'(usable_blocks() * bsize_cfg);
      if (req.addr == '0 || req.addr < base_cfg || {1'b0, req.addr} >= pool_lim) begin
        res.status = ST_IGNORED;
      end else if (free_depth >= MAX_BLOCKS) begin
        res.status = ST_FULL;
      end else begin
        free_offsets[free_depth[PTR_W-1:0]] = OFF_W'(req.addr - base_cfg);
        free_depth = free_depth + 1'b1;
      end
    end
  endtask

  always @(posedge clk) begin : watch
    item_t   req;
    result_t want;
    if (!rst_n) begin
      base_cfg  = '0;
      bsize_cfg = RESET_BLOCK_SIZE;
      nblk_cfg  = RESET_NUM_BLOCKS;
      rebuild_free_list();
      pending_results.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_POOL_BASE: begin
            base_cfg = cfg_wr_data;
            rebuild_free_list();
          end
          CFG_BLOCK_SIZE: begin
            bsize_cfg = cfg_wr_data[SIZE_W-1:0];
            rebuild_free_list();
          end
          CFG_NUM_BLOCKS: begin
            nblk_cfg = cfg_wr_data[NBLK_W-1:0];
            rebuild_free_list();
          end
          default: ;
        endcase
      end
      if (out_valid === 1'b1 && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("unexpected result transfer: block_address %h status %0d",
                 out_block_address, out_status);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (out_block_address !== want.addr) begin
            $error("block_address mismatch: expected %h, actual %h",
                   want.addr, out_block_address);
            fail_count++;
          end
          if (out_status !== want.status) begin
            $error("status mismatch: expected %0d, actual %0d", want.status, out_status);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready === 1'b1) begin
        req.op    = op_t'(in_operation);
        req.size  = in_request_size;
        req.align = in_alignment;
        req.addr  = in_release_address;
        predict_alloc_result(req, want);
        pending_results.insert(pending_results.size(), want);
      end
    end
    outstanding <= pending_results.size();
  end

endmodule

@@ bench/tb_fixed_block_pool_allocator_core.sv @@
// Testbench top: clock, reset, stimulus and verdict for the block pool allocator.
module tb_fixed_block_pool_allocator_core;
  import fbpa_pkg::*;

  // How the two channels idle during a phase of the run.
  typedef enum int {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  // The register map has three entries; the fourth index must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

  logic                  clk;
  logic                  rst_n              = 1'b0;
  logic                  in_valid           = 1'b0;
  logic                  in_ready;
  logic                  in_operation       = 1'b0;
  logic [SIZE_W-1:0]     in_request_size    = '0;
  logic [SIZE_W-1:0]     in_alignment       = '0;
  logic [ADDR_W-1:0]     in_release_address = '0;
  logic                  out_valid;
  logic                  out_ready          = 1'b0;
  logic [ADDR_W-1:0]     out_block_address;
  logic [STATUS_W-1:0]   out_status;
  logic                  cfg_wr_en          = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index          = '0;
  logic [CFG_DATA_W-1:0] cfg_wr_data        = '0;

  int                    fail_count;
  int                    pending;

  // The stimulus keeps its own copy of the pool layout so it can aim releases
  // into the pool; prediction lives entirely in the checker.
  logic [ADDR_W-1:0]     cur_base = '0;
  logic [SIZE_W-1:0]     cur_bs   = 16'd64;
  logic [NBLK_W-1:0]     cur_nb   = 9'd256;

  int unsigned           send_gap_pct   = 0;
  int unsigned           recv_stall_pct = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  fixed_block_pool_allocator_core u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_request_size    (in_request_size),
    .in_alignment       (in_alignment),
    .in_release_address (in_release_address),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_block_address  (out_block_address),
    .out_status         (out_status),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wr_data        (cfg_wr_data)
  );

  fbpa_alloc_checker u_check (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_request_size    (in_request_size),
    .in_alignment       (in_alignment),
    .in_release_address (in_release_address),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_block_address  (out_block_address),
    .out_status         (out_status),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_wr_data        (cfg_wr_data),
    .fail_count         (fail_count),
    .outstanding        (pending)
  );

  // The result side stalls at random according to the current idling mode.
  // This is the only place out_ready is driven, so it changes only at clock edges.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_SENDER: begin
        send_gap_pct   = 65;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_gap_pct   = 0;
        recv_stall_pct = 65;
      end
      IDLE_BOTH: begin
        send_gap_pct   = 19;
        recv_stall_pct = 19;
      end
      default: begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
    endcase
  endtask

  // Presents one request and returns at the edge where its transfer happens.
  // Valid is left high afterwards so that back-to-back requests never drop it;
  // a gap lowers it for whole cycles only.
  task automatic send_item(input op_t op, input logic [SIZE_W-1:0] size,
                           input logic [SIZE_W-1:0] align, input logic [ADDR_W-1:0] addr);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_operation       <= op;
    in_request_size    <= size;
    in_alignment       <= align;
    in_release_address <= addr;
    do @(posedge clk); while (in_ready !== 1'b1);
  endtask

  // Most traffic is well-formed: allocations that fit the block size with small
  // power-of-two alignments, and releases of block addresses inside the pool.
  // The rest is oversized requests, odd alignments and stray release addresses.
  task automatic send_random_item();
    int unsigned       pick;
    int unsigned       eff;
    logic [SIZE_W-1:0] sz;
    logic [SIZE_W-1:0] al;
    logic [ADDR_W-1:0] ad;
    pick = $urandom_range(99);
    eff  = (cur_nb > MAX_BLOCKS) ? MAX_BLOCKS : cur_nb;
    sz   = SIZE_W'($urandom());
    al   = SIZE_W'($urandom());
    ad   = $urandom();
    if (pick < 48) begin
      if ($urandom_range(9) != 0) begin
        sz = SIZE_W'($urandom_range(cur_bs));
      end
      case ($urandom_range(9))
        0:       al = '0;
        1:       ;
        2:       al = SIZE_W'(1) << $urandom_range(15);
        default: al = SIZE_W'(1) << $urandom_range(4);
      endcase
      send_item(OP_ALLOC, sz, al, ad);
    end else if (pick < 92 && eff != 0) begin
      if (cur_bs != 0 && $urandom_range(7) == 0) begin
        // Anywhere inside the pool, not only at a block start.
        ad = cur_base + $urandom_range(eff * cur_bs - 1);
      end else begin
        ad = cur_base + $urandom_range(eff - 1) * cur_bs;
      end
      send_item(OP_RELEASE, sz, al, ad);
    end else begin
      case ($urandom_range(3))
        0:       ad = '0;
        1:       ad = cur_base + eff * cur_bs;
        2:       ad = cur_base - 1;
        default: ;
      endcase
      send_item(OP_RELEASE, sz, al, ad);
    end
  endtask

  // Drops valid and waits until every expected result has been delivered.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= data;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_POOL_BASE:  cur_base = data;
      CFG_BLOCK_SIZE: cur_bs   = data[SIZE_W-1:0];
      CFG_NUM_BLOCKS: cur_nb   = data[NBLK_W-1:0];
      default: ;
    endcase
  endtask

  // One phase: wait for the allocator to go quiet, load a new pool layout
  // (each write rebuilds the free stack), then run random traffic.
  task automatic run_phase(input logic [ADDR_W-1:0] base, input logic [SIZE_W-1:0] bs,
                           input logic [NBLK_W-1:0] nb, input idle_mode_t mode,
                           input int unsigned count);
    drain();
    cfg_write(CFG_POOL_BASE, base);
    cfg_write(CFG_BLOCK_SIZE, CFG_DATA_W'(bs));
    cfg_write(CFG_NUM_BLOCKS, CFG_DATA_W'(nb));
    set_idling(mode);
    repeat (count) send_random_item();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed requests against the reset layout: base 0, 64-byte blocks,
    // 256 blocks, so the free stack starts out full.
    set_idling(IDLE_NONE);
    send_item(OP_RELEASE, '0, '0, 32'd64);          // stack already full
    send_item(OP_ALLOC, 16'd64, 16'd1, '0);         // exact block size fits
    send_item(OP_ALLOC, 16'd65, 16'd1, '0);         // one byte too large
    send_item(OP_ALLOC, 16'hFFFF, 16'd0, '0);       // size is checked before alignment
    send_item(OP_ALLOC, 16'd0, 16'd0, '0);          // zero alignment
    send_item(OP_ALLOC, 16'd16, 16'd3, '0);         // alignment not a power of two
    send_item(OP_ALLOC, 16'd16, 16'hFFFF, '0);
    send_item(OP_ALLOC, 16'd16, 16'h8000, '0);      // top block misaligned, stays put
    send_item(OP_ALLOC, 16'd16, 16'd64, '0);        // same block now taken
    send_item(OP_RELEASE, '0, '0, 32'd0);           // null pointer
    send_item(OP_RELEASE, '0, '0, 32'd16384);       // first byte past the pool
    send_item(OP_RELEASE, '0, '0, 32'hFFFF_FFFF);
    send_item(OP_RELEASE, '0, '0, 32'd64);
    send_item(OP_RELEASE, '0, '0, 32'd64);          // double release goes through
    send_item(OP_RELEASE, '0, '0, 32'd100);         // address inside a block; stack is full again
    send_item(OP_ALLOC, 16'd1, 16'd8, '0);          // doubled block at offset 64, 8-aligned
    send_item(OP_ALLOC, 16'd1, 16'd4, '0);
    send_item(OP_ALLOC, 16'd1, 16'd64, '0);
    send_item(OP_ALLOC, 16'd1, 16'd64, '0);         // another block from the reset layout
    send_item(OP_RELEASE, '0, '0, 32'd16383);       // last byte of the pool

    set_idling(IDLE_BOTH);
    repeat (150) send_random_item();

    // Fixed layouts that cover the extremes of every register.
    run_phase(32'h0000_1000, 16'd64, 9'd8, IDLE_NONE, 150);
    run_phase(32'h0000_0000, 16'd1, 9'd1, IDLE_SENDER, 120);        // block at address zero
    run_phase(32'hFFFF_FF00, 16'd16, 9'd16, IDLE_RECEIVER, 150);    // addresses wrap
    run_phase(32'hFFFF_FFFF, 16'hFFFF, 9'd256, IDLE_BOTH, 120);
    run_phase(32'h0000_0100, 16'd32, 9'd0, IDLE_SENDER, 50);        // empty pool
    run_phase(32'h0000_0040, 16'd0, 9'd4, IDLE_RECEIVER, 50);       // zero-sized blocks
    run_phase(32'h0000_0200, 16'd4, 9'h1FF, IDLE_BOTH, 150);        // count above the depth

    // A write to the unused index must leave the layout and the stack alone.
    drain();
    cfg_write(CFG_UNUSED_IDX, $urandom());
    set_idling(IDLE_NONE);
    repeat (30) send_random_item();

    for (int k = 0; k < 4; k++) begin
      run_phase(($urandom_range(1) != 0) ? $urandom() : ADDR_W'($urandom_range(4095)) << 4,
                SIZE_W'($urandom_range(256, 1)), NBLK_W'($urandom_range(64, 1)),
                idle_mode_t'(k), 100);
    end

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Hard stop in case a handshake hangs.
  initial begin
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
